>>> src/life_automaton_board_assert.svh
// assertion macros shared by the life board rtl
// no dependencies; included by the modules that carry assertions
`ifndef LIFE_AUTOMATON_BOARD_ASSERT_SVH
`define LIFE_AUTOMATON_BOARD_ASSERT_SVH

// same-cycle implication under the async active-low reset
`define LAB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("life board check failed");

// next-cycle implication under the async active-low reset
`define LAB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("life board check failed");

`endif

>>> src/lab_pkg.sv
// shared types, codes and constants of the life board
// no dependencies; imported by every module of the block
package lab_pkg;

	// default board bounds
	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_MAX_COLS = 64;

	// configuration port
	localparam int CFG_DATA_W = 7;
	localparam int CFG_IDX_W  = 1;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;
	localparam int SIZE_AT_RESET = 10;

	// command codes
	localparam logic [1:0] KIND_WRITE   = 2'd0;
	localparam logic [1:0] KIND_READ    = 2'd1;
	localparam logic [1:0] KIND_ADVANCE = 2'd2;

	// b3/s23 neighbor counts
	localparam logic [3:0] BIRTH_COUNT = 4'd3;
	localparam logic [3:0] KEEP_COUNT  = 4'd2;

	// input beat
	typedef struct packed {
		logic [1:0] kind;
		logic [5:0] row;
		logic [5:0] col;
		logic       alive;
	} lab_in_t;

	// output beat
	typedef struct packed {
		logic cell_value;
		logic index_error;
	} lab_out_t;

	// control shared by all row cells of the ring
	typedef struct packed {
		logic shift;
		logic clear;
	} lab_ring_ctl_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PASS,
		ST_FINISH
	} lab_state_t;

endpackage

>>> src/lab_row_cell.sv
// one row cell of the board ring: holds one row, takes its neighbor's row on a shift
// depends on lab_pkg
module lab_row_cell
	import lab_pkg::*;
#(
	parameter int W = DEF_MAX_COLS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  lab_ring_ctl_t ctl,
	input  logic [W-1:0]  d,
	output logic [W-1:0]  q
);

	logic [W-1:0] row_q;

	// row storage: clear wins over shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (ctl.clear) begin
			row_q <= '0;
		end else if (ctl.shift) begin
			row_q <= d;
		end
	end

	assign q = row_q;

endmodule

>>> src/lab_row_rule.sv
// next-generation rule for one row from the old rows above, at and below
// depends on lab_pkg
module lab_row_rule
	import lab_pkg::*;
#(
	parameter int W = DEF_MAX_COLS
) (
	input  logic [W-1:0] above,
	input  logic [W-1:0] mid,
	input  logic [W-1:0] below,
	input  logic [W-1:0] col_mask,
	output logic [W-1:0] next
);

	logic [W+1:0] ae;
	logic [W+1:0] me;
	logic [W+1:0] be;

	// pad with dead cells at both board edges
	assign ae = {1'b0, above & col_mask, 1'b0};
	assign me = {1'b0, mid & col_mask, 1'b0};
	assign be = {1'b0, below & col_mask, 1'b0};

	// count eight neighbors for every column and apply the rule
	always_comb begin
		logic [3:0] n;
		n = '0;
		for (int c = 0; c < W; c++) begin
			n = 4'(ae[c]) + 4'(ae[c+1]) + 4'(ae[c+2])
			  + 4'(me[c]) + 4'(me[c+2])
			  + 4'(be[c]) + 4'(be[c+1]) + 4'(be[c+2]);
			next[c] = col_mask[c]
				& ((n == BIRTH_COUNT) | (me[c+1] & (n == KEEP_COUNT)));
		end
	end

endmodule

>>> src/life_automaton_board.sv
// life board top: ring of row cells, rule unit, controller and output register
// depends on lab_pkg, lab_row_cell, lab_row_rule and life_automaton_board_assert.svh
//
//  channel   signals                          beat contents
//  in        in_valid / in_ready / in_data    kind, row, col, alive
//  out       out_valid / out_ready / out_data cell_value, index_error
//  cfg       cfg_we / cfg_index / cfg_data    rows_in_use, cols_in_use
//
// a good write, read or advance goes through PASS and then FINISH: the ring of row cells
// rotates once, so every row passes the head cell where it is read, written or
// recomputed. a bad index or unused kind goes from IDLE straight to FINISH.
// arst_n clears the board, the sizes go to 10 (clamped) and the ring stops.
// a size write clears the whole board.
// while out is stalled the finished result waits in FINISH; a new beat is taken
// as soon as the result sits in the output register.
`include "life_automaton_board_assert.svh"

module life_automaton_board
	import lab_pkg::*;
#(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  lab_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output lab_out_t              out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SW  = $clog2(MAX_ROWS);
	localparam int RW  = $clog2(MAX_ROWS + 1);
	localparam int CW  = $clog2(MAX_COLS + 1);
	localparam int CIW = $clog2(MAX_COLS);
	localparam int RCW = (RW > CFG_DATA_W) ? RW : CFG_DATA_W;
	localparam int CCW = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;
	localparam int MW  = (SW > 6) ? SW : 6;
	localparam int ROWS_RST = (MAX_ROWS < SIZE_AT_RESET) ? MAX_ROWS : SIZE_AT_RESET;
	localparam int COLS_RST = (MAX_COLS < SIZE_AT_RESET) ? MAX_COLS : SIZE_AT_RESET;
	localparam logic [SW-1:0] LAST_STEP = SW'(MAX_ROWS - 1);

	lab_state_t      state_q, state_d;
	logic [SW-1:0]   step_q;
	logic [RW-1:0]   rows_q;
	logic [CW-1:0]   cols_q;
	lab_in_t         req_q;
	lab_out_t        res_q;
	logic [MAX_COLS-1:0] old_above_q;
	logic            out_valid_q;
	lab_out_t        out_data_q;

	lab_ring_ctl_t   ring_ctl;
	logic [MAX_COLS-1:0] ring_row [MAX_ROWS];
	logic [MAX_COLS-1:0] tail_d;
	logic [MAX_COLS-1:0] head_wr;
	logic [MAX_COLS-1:0] below_row;
	logic [MAX_COLS-1:0] rule_row;
	logic [MAX_COLS-1:0] col_mask;

	logic            in_fire;
	logic            load_out;
	logic            in_bad;
	logic            at_target;
	logic            row_active;
	logic            below_ok;
	logic [CIW-1:0]  col_idx;
	logic [RCW-1:0]  rows_cfg;
	logic [CCW-1:0]  cols_cfg;

	// size registers with clamping
	assign rows_cfg = (RCW'(cfg_data) == '0) ? RCW'(1)
		: (RCW'(cfg_data) > RCW'(MAX_ROWS)) ? RCW'(MAX_ROWS) : RCW'(cfg_data);
	assign cols_cfg = (CCW'(cfg_data) == '0) ? CCW'(1)
		: (CCW'(cfg_data) > CCW'(MAX_COLS)) ? CCW'(MAX_COLS) : CCW'(cfg_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= RW'(ROWS_RST);
			cols_q <= CW'(COLS_RST);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROWS: rows_q <= RW'(rows_cfg);
				REG_COLS: cols_q <= CW'(cols_cfg);
				default: ;
			endcase
		end
	end

	// columns in use
	always_comb begin
		for (int c = 0; c < MAX_COLS; c++) begin
			col_mask[c] = (CW'(c) < cols_q);
		end
	end

	// index check on the incoming beat
	assign in_bad = ((RCW'(in_data.row) >= RCW'(rows_q))
		|| (CCW'(in_data.col) >= CCW'(cols_q)));

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;

	// ring of row cells: cell 0 is the head, the tail takes the updated head row
	genvar gi;
	generate
		for (gi = 0; gi < MAX_ROWS; gi++) begin : g_ring
			if (gi == MAX_ROWS - 1) begin : g_tail
				lab_row_cell #(.W(MAX_COLS)) u_cell (
					.clk    (clk),
					.arst_n (arst_n),
					.ctl    (ring_ctl),
					.d      (tail_d),
					.q      (ring_row[gi])
				);
			end else begin : g_body
				lab_row_cell #(.W(MAX_COLS)) u_cell (
					.clk    (clk),
					.arst_n (arst_n),
					.ctl    (ring_ctl),
					.d      (ring_row[gi+1]),
					.q      (ring_row[gi])
				);
			end
		end
	endgenerate

	// head row position within the pass
	assign col_idx    = CIW'(req_q.col);
	assign at_target  = (MW'(step_q) == MW'(req_q.row));
	assign row_active = (RW'(step_q) < rows_q);
	assign below_ok   = ((RW'(step_q) + RW'(1)) < rows_q);
	assign below_row  = below_ok ? ring_row[1] : '0;

	lab_row_rule #(.W(MAX_COLS)) u_rule (
		.above    (old_above_q),
		.mid      (ring_row[0]),
		.below    (below_row),
		.col_mask (col_mask),
		.next     (rule_row)
	);

	// row handed to the tail
	always_comb begin
		head_wr          = ring_row[0];
		head_wr[col_idx] = req_q.alive;
		tail_d           = ring_row[0];
		case (req_q.kind)
			KIND_ADVANCE: if (row_active) begin
				tail_d = rule_row;
			end
			KIND_WRITE: if (at_target) begin
				tail_d = head_wr;
			end
			default: ;
		endcase
	end

	// controller next state and strobes
	always_comb begin
		state_d        = state_q;
		ring_ctl.shift = 1'b0;
		ring_ctl.clear = cfg_we && ((cfg_index == REG_ROWS) || (cfg_index == REG_COLS));
		load_out       = 1'b0;
		case (state_q)
			ST_IDLE: if (in_fire) begin
				if ((in_data.kind == KIND_ADVANCE)
					|| (((in_data.kind == KIND_WRITE) || (in_data.kind == KIND_READ))
					&& !in_bad)) begin
					state_d = ST_PASS;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_PASS: begin
				ring_ctl.shift = 1'b1;
				if (step_q == LAST_STEP) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: if (!out_valid_q || out_ready) begin
				load_out = 1'b1;
				state_d  = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_PASS) begin
				step_q <= (step_q == LAST_STEP) ? '0 : step_q + SW'(1);
			end
		end
	end

	// request, result and old row above
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			old_above_q <= '0;
		end else if (in_fire) begin
			old_above_q <= '0;
		end else if (state_q == ST_PASS) begin
			old_above_q <= ring_row[0];
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_q             <= in_data;
			res_q.cell_value  <= 1'b0;
			res_q.index_error <= ((in_data.kind == KIND_WRITE) || (in_data.kind == KIND_READ))
				&& in_bad;
		end else if ((state_q == ST_PASS) && (req_q.kind == KIND_READ) && at_target) begin
			res_q.cell_value <= ring_row[0][col_idx];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// checks
	`LAB_ASSERT_NEXT(a_pass_ends, clk, arst_n,
		(state_q == ST_PASS) && (step_q == LAST_STEP), state_q == ST_FINISH)
	`LAB_ASSERT_NEXT(a_accept_busy, clk, arst_n, in_fire, state_q != ST_IDLE)
	`LAB_ASSERT_NOW(a_idle_step, clk, arst_n, state_q == ST_IDLE, step_q == '0)
	`LAB_ASSERT_NOW(a_out_source, clk, arst_n, $rose(out_valid_q), $past(state_q == ST_FINISH))

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// testbench of life_automaton_board: directed and random cell commands checked beat by beat
// against a b3/s23 board predictor held in a small scoreboard class
// depends on lab_pkg and life_automaton_board
module tb
	import lab_pkg::*;
();

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = DEF_MAX_ROWS + 6;
	localparam int ITEM_TARGET    = 1650;
	localparam int MAX_REPORTS    = 10;
	localparam int IDLE_PCT       = 27;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	// board predictor and queue of expected result beats
	class life_scoreboard;
		logic [DEF_MAX_COLS-1:0] cells   [DEF_MAX_ROWS];
		logic [DEF_MAX_COLS-1:0] old_gen [DEF_MAX_ROWS];
		int unsigned n_rows;
		int unsigned n_cols;
		lab_out_t    expected_q [$];
		int unsigned n_done;
		int unsigned n_errors;

		function new();
			foreach (cells[r]) cells[r] = '0;
			n_rows   = clamp_size(SIZE_AT_RESET, DEF_MAX_ROWS);
			n_cols   = clamp_size(SIZE_AT_RESET, DEF_MAX_COLS);
			n_done   = 0;
			n_errors = 0;
		endfunction

		function int unsigned clamp_size(int unsigned v, int unsigned top);
			if (v < 1) return 1;
			if (v > top) return top;
			return v;
		endfunction

		function void report(string msg);
			n_errors++;
			if (n_errors <= MAX_REPORTS) $display("%s", msg);
		endfunction

		// any size write clears the whole board
		function void set_size(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == REG_ROWS) n_rows = clamp_size(32'(val), DEF_MAX_ROWS);
			else n_cols = clamp_size(32'(val), DEF_MAX_COLS);
			foreach (cells[r]) cells[r] = '0;
		endfunction

		// cells outside the board in use count as dead
		function int old_cell(int r, int c);
			if (r < 0 || r >= int'(n_rows) || c < 0 || c >= int'(n_cols)) return 0;
			return int'(old_gen[r][c]);
		endfunction

		// one generation, every cell from the old board
		function void advance_board();
			int cnt;
			old_gen = cells;
			for (int r = 0; r < int'(n_rows); r++) begin
				for (int c = 0; c < int'(n_cols); c++) begin
					cnt = 0;
					for (int dr = -1; dr <= 1; dr++)
						for (int dc = -1; dc <= 1; dc++)
							if (dr != 0 || dc != 0) cnt += old_cell(r + dr, c + dc);
					if (old_gen[r][c])
						cells[r][c] = (cnt == int'(KEEP_COUNT) || cnt == int'(BIRTH_COUNT));
					else cells[r][c] = (cnt == int'(BIRTH_COUNT));
				end
			end
		endfunction

		// accepted command beat: apply it and queue its result
		function void note_input(lab_in_t cmd);
			lab_out_t res;
			bit       bad;
			res = '0;
			bad = (32'(cmd.row) >= n_rows) || (32'(cmd.col) >= n_cols);
			case (cmd.kind)
				KIND_WRITE: begin
					if (bad) res.index_error = 1'b1;
					else cells[cmd.row][cmd.col] = cmd.alive;
				end
				KIND_READ: begin
					if (bad) res.index_error = 1'b1;
					else res.cell_value = cells[cmd.row][cmd.col];
				end
				KIND_ADVANCE: advance_board();
				default: ;
			endcase
			expected_q.push_back(res);
		endfunction

		// accepted result beat: compare with the oldest expectation
		function void check_result(lab_out_t got);
			lab_out_t exp_res;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result beat: cell_value %0b index_error %0b",
					got.cell_value, got.index_error));
				return;
			end
			exp_res = expected_q.pop_front();
			if (got.cell_value !== exp_res.cell_value)
				report($sformatf("beat %0d cell_value: expected %0b, got %0b",
					n_done, exp_res.cell_value, got.cell_value));
			if (got.index_error !== exp_res.index_error)
				report($sformatf("beat %0d index_error: expected %0b, got %0b",
					n_done, exp_res.index_error, got.index_error));
			n_done++;
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	lab_in_t               in_data   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	lab_out_t              out_data;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	life_scoreboard sb = new();
	int unsigned    idle_pct     = IDLE_PCT;
	int unsigned    n_sent       = 0;
	int unsigned    quiet_cycles = 0;

	life_automaton_board #(
		.MAX_ROWS(DEF_MAX_ROWS),
		.MAX_COLS(DEF_MAX_COLS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side stalls
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= idle_pct);
	end

	// monitor: register writes, accepted beats and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) sb.set_size(cfg_index, cfg_data);
			if (in_valid && in_ready) sb.note_input(in_data);
			if (out_valid && out_ready) sb.check_result(out_data);
			if (cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// one command beat, with a random gap in front
	task automatic push_cmd(input logic [1:0] kind, input int unsigned row,
		input int unsigned col, input bit alive);
		lab_in_t cmd;
		cmd.kind  = kind;
		cmd.row   = row[5:0];
		cmd.col   = col[5:0];
		cmd.alive = alive;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= cmd;
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		@(posedge clk);
		n_sent++;
	endtask

	// stop sending and wait for every outstanding result
	task automatic wait_drained(input int unsigned extra);
		in_valid <= 1'b0;
		@(negedge clk);
		while (sb.n_done != n_sent) @(negedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// out-of-range, unused-kind and stray beats
	task automatic push_noise();
		int unsigned r;
		int unsigned c;
		r = (sb.n_rows < 64 && $urandom_range(1)) ? $urandom_range(63, sb.n_rows)
			: $urandom_range(63);
		c = (sb.n_cols < 64 && $urandom_range(1)) ? $urandom_range(63, sb.n_cols)
			: $urandom_range(63);
		case ($urandom_range(3))
			0: push_cmd(KIND_WRITE, r, c, 1'($urandom_range(1)));
			1: push_cmd(KIND_READ, r, c, 1'($urandom_range(1)));
			2: push_cmd(KIND_UNUSED, $urandom_range(63), $urandom_range(63),
				1'($urandom_range(1)));
			default: push_cmd(KIND_READ, $urandom_range(63), $urandom_range(63), 1'b0);
		endcase
	endtask

	// seed a window, let it evolve, read it back
	task automatic run_phase(input int unsigned n_items);
		int unsigned stop_at;
		int unsigned r0;
		int unsigned c0;
		int unsigned span_r;
		int unsigned span_c;
		stop_at = n_sent + n_items;
		while (n_sent < stop_at) begin
			span_r = $urandom_range(8, 3);
			span_c = $urandom_range(8, 3);
			if (span_r > sb.n_rows) span_r = sb.n_rows;
			if (span_c > sb.n_cols) span_c = sb.n_cols;
			r0 = $urandom_range(sb.n_rows - span_r);
			c0 = $urandom_range(sb.n_cols - span_c);
			// favor the board edges now and then
			if ($urandom_range(3) == 0) r0 = $urandom_range(1) ? 0 : sb.n_rows - span_r;
			if ($urandom_range(3) == 0) c0 = $urandom_range(1) ? 0 : sb.n_cols - span_c;
			repeat ($urandom_range(16, 2)) begin
				if ($urandom_range(99) < 8) push_noise();
				push_cmd(KIND_WRITE, r0 + $urandom_range(span_r - 1),
					c0 + $urandom_range(span_c - 1), $urandom_range(99) < 70);
			end
			repeat ($urandom_range(5, 1)) begin
				push_cmd(KIND_ADVANCE, $urandom_range(63), $urandom_range(63),
					1'($urandom_range(1)));
				repeat ($urandom_range(4)) begin
					push_cmd(KIND_READ, r0 + $urandom_range(span_r - 1),
						c0 + $urandom_range(span_c - 1), 1'($urandom_range(1)));
				end
				if ($urandom_range(99) < 15) push_noise();
			end
		end
	endtask

	task automatic resize(input logic [CFG_DATA_W-1:0] rows_val,
		input logic [CFG_DATA_W-1:0] cols_val, input int unsigned which);
		wait_drained(4);
		if (which != 2) write_reg(REG_ROWS, rows_val);
		if (which != 1) write_reg(REG_COLS, cols_val);
	endtask

	// stimulus
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed on the 10 x 10 board after reset
		push_cmd(KIND_READ, 0, 0, 1'b1);
		push_cmd(KIND_WRITE, 0, 0, 1'b1);
		push_cmd(KIND_READ, 0, 0, 1'b0);
		push_cmd(KIND_WRITE, 9, 9, 1'b1);
		push_cmd(KIND_READ, 9, 9, 1'b0);
		// bad indexes
		push_cmd(KIND_WRITE, 63, 63, 1'b1);
		push_cmd(KIND_READ, 10, 0, 1'b0);
		push_cmd(KIND_READ, 0, 10, 1'b0);
		push_cmd(KIND_WRITE, 0, 0, 1'b0);
		push_cmd(KIND_READ, 0, 0, 1'b0);
		// unused kind
		push_cmd(KIND_UNUSED, 63, 63, 1'b1);
		push_cmd(KIND_UNUSED, 0, 0, 1'b0);
		// blinker turns vertical, lone cell in the corner dies
		push_cmd(KIND_WRITE, 4, 3, 1'b1);
		push_cmd(KIND_WRITE, 4, 4, 1'b1);
		push_cmd(KIND_WRITE, 4, 5, 1'b1);
		push_cmd(KIND_ADVANCE, 0, 0, 1'b0);
		push_cmd(KIND_READ, 3, 4, 1'b0);
		push_cmd(KIND_READ, 4, 3, 1'b0);
		push_cmd(KIND_READ, 5, 4, 1'b0);
		// birth against the top left edge
		push_cmd(KIND_WRITE, 0, 0, 1'b1);
		push_cmd(KIND_WRITE, 0, 1, 1'b1);
		push_cmd(KIND_WRITE, 1, 0, 1'b1);
		push_cmd(KIND_ADVANCE, 63, 63, 1'b1);
		push_cmd(KIND_READ, 1, 1, 1'b0);
		push_cmd(KIND_READ, 9, 9, 1'b0);

		// rewriting the same size still clears the board
		resize(7'd10, 7'd10, 1);
		push_cmd(KIND_READ, 3, 4, 1'b0);
		push_cmd(KIND_READ, 0, 0, 1'b0);
		run_phase(40);

		// size extremes, clamping and one long run without gaps
		resize(7'd1, 7'd1, 0);
		run_phase(40);
		resize(7'd64, 7'd64, 0);
		idle_pct = 0;
		run_phase(200);
		idle_pct = IDLE_PCT;
		resize(7'd0, 7'd127, 0);
		run_phase(60);
		resize(7'd127, 7'd0, 0);
		run_phase(60);
		resize(7'd65, 7'd2, 0);
		run_phase(50);

		// random sizes, mostly small
		while (n_sent < ITEM_TARGET) begin
			if ($urandom_range(99) < 70)
				resize(7'($urandom_range(16, 2)), 7'($urandom_range(16, 2)),
					$urandom_range(2));
			else
				resize(7'($urandom_range(127)), 7'($urandom_range(127)),
					$urandom_range(2));
			run_phase($urandom_range(120, 40));
		end

		wait_drained(SETTLE_CYCLES);
		if (sb.n_errors == 0 && sb.expected_q.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
